FILE: rtl/pafbf_pkg.sv
package pafbf_pkg;

   localparam int MEMORY_UNITS  = 32768;
   localparam int SEGMENT_SLOTS = 64;

   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_RELEASE  = 1'b1;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BAD_REQUEST = 2'd1;
   localparam logic [1:0] ST_BAD_RELEASE = 2'd2;
   localparam logic [1:0] ST_TABLE_FULL  = 2'd3;

   localparam logic [2:0] CSR_FIT_MODE_ADDR = 3'd0;
   localparam logic       FIT_FIRST = 1'b0;

   typedef struct packed {
      logic [14:0] seg_start;
      logic [15:0] seg_length;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_REFRESH,
      S_DONE
   } state_type;

endpackage

FILE: rtl/partition_allocator_first_best_fit.sv
// Variable-partition allocator over a table of free segments held in one
// synchronous RAM (one read and one write port, registered read data).
// An accepted item keeps busy high through one pass over the table to
// select or find merge neighbours, the write-back state, and a second
// pass to recompute the largest free size (an overlapping release stops
// after the first pass, a full table after write-back). Each pass reads
// one entry a cycle and then drains the read pipeline. Requests rejected
// up front (zero size, too large, past the memory end) skip the passes,
// with the result in the cycle after the item is accepted.
// Each result appears on the rsp_ ports for exactly one cycle with
// rsp_strobe high; the receiver cannot stall it, so it must take it then.
module partition_allocator_first_best_fit #(
   parameter int SEGMENT_SLOTS = pafbf_pkg::SEGMENT_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [15:0] req_region_size,
   input  logic [14:0] req_region_start,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [14:0] rsp_granted_start,
   output logic [15:0] rsp_largest_free,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pafbf_pkg::*;

   localparam int IW = $clog2(SEGMENT_SLOTS);
   localparam logic [IW:0]   SLOT_CNT = (IW+1)'(SEGMENT_SLOTS);
   localparam logic [16:0]   MEM_END  = 17'(MEMORY_UNITS);
   localparam logic [15:0]   MEM_LEN  = 16'(MEMORY_UNITS);

   entry_type mem [SEGMENT_SLOTS];

   state_type state_ff, state_in;
   logic [SEGMENT_SLOTS-1:0] valid_ff, valid_in;
   logic init0_ff, init0_in;
   logic fit_ff;

   entry_type rd_data_ff;
   logic [IW-1:0] rd_idx_ff;
   logic rd_v_ff, rd_init_ff, rd_pend_ff, rd_pend_in;
   logic [IW:0] cnt_ff, cnt_in;

   logic cmd_ff, cmd_in;
   logic [15:0] size_ff, size_in;
   logic [14:0] start_ff, start_in;
   logic [16:0] end_ff, end_in;

   logic found_ff, found_in;
   logic [IW-1:0] pick_ff, pick_in;
   logic [14:0] pick_start_ff, pick_start_in;
   logic [15:0] pick_len_ff, pick_len_in;
   logic prev_f_ff, prev_f_in, next_f_ff, next_f_in, spare_f_ff, spare_f_in;
   logic [IW-1:0] prev_ff, prev_in, next_ff, next_in, spare_ff, spare_in;
   logic [15:0] prev_len_ff, prev_len_in, next_len_ff, next_len_in;
   logic overlap_ff, overlap_in;
   logic [15:0] largest_ff, largest_in, max_ff, max_in;
   logic [1:0] status_ff, status_in;
   logic [14:0] granted_ff, granted_in;

   logic mem_we;
   logic [IW-1:0] mem_wa;
   entry_type mem_wd;

   logic [14:0] e_start;
   logic [15:0] e_len;
   logic [16:0] e_end;
   logic [16:0] req_end;
   logic [15:0] new_len;
   logic accept, cfg_we;

   assign accept     = start && (state_ff == S_IDLE);
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);
   assign rsp_status = status_ff;
   assign rsp_granted_start = granted_ff;
   assign rsp_largest_free  = largest_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, fit_ff};
   assign cfg_we = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_FIT_MODE_ADDR);

   assign req_end = {2'b00, req_region_start} + {1'b0, req_region_size};
   assign new_len = pick_len_ff - size_ff;

   // entry as seen by the scan: invalid slots read empty, entry 0 full
   // until first written
   always_comb begin
      if (!rd_v_ff) begin
         e_start = '0;
         e_len   = '0;
      end else if (rd_init_ff) begin
         e_start = '0;
         e_len   = MEM_LEN;
      end else begin
         e_start = rd_data_ff.seg_start;
         e_len   = rd_data_ff.seg_length;
      end
      e_end = {2'b00, e_start} + {1'b0, e_len};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[cnt_ff[IW-1:0]];
      rd_idx_ff  <= cnt_ff[IW-1:0];
      rd_v_ff    <= valid_ff[cnt_ff[IW-1:0]];
      rd_init_ff <= init0_ff && (cnt_ff[IW-1:0] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= SEGMENT_SLOTS'(1);
         init0_ff   <= 1'b1;
         fit_ff     <= FIT_FIRST;
         largest_ff <= MEM_LEN;
         rd_pend_ff <= 1'b0;
         cnt_ff     <= '0;
         status_ff  <= ST_OK;
         granted_ff <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         init0_ff   <= init0_in;
         largest_ff <= largest_in;
         rd_pend_ff <= rd_pend_in;
         cnt_ff     <= cnt_in;
         status_ff  <= status_in;
         granted_ff <= granted_in;
         if (cfg_we) begin
            fit_ff <= csr_pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      pick_start_ff <= pick_start_in;
      pick_len_ff   <= pick_len_in;
      prev_f_ff     <= prev_f_in;
      next_f_ff     <= next_f_in;
      spare_f_ff    <= spare_f_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      spare_ff      <= spare_in;
      prev_len_ff   <= prev_len_in;
      next_len_ff   <= next_len_in;
      overlap_ff    <= overlap_in;
      max_ff        <= max_in;
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      init0_in      = init0_ff;
      largest_in    = largest_ff;
      rd_pend_in    = 1'b0;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      granted_in    = granted_ff;
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      pick_start_in = pick_start_ff;
      pick_len_in   = pick_len_ff;
      prev_f_in     = prev_f_ff;
      next_f_in     = next_f_ff;
      spare_f_in    = spare_f_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      spare_in      = spare_ff;
      prev_len_in   = prev_len_ff;
      next_len_in   = next_len_ff;
      overlap_in    = overlap_ff;
      max_in        = max_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in     = req_command;
               size_in    = req_region_size;
               start_in   = req_region_start;
               end_in     = req_end;
               found_in   = 1'b0;
               prev_f_in  = 1'b0;
               next_f_in  = 1'b0;
               spare_f_in = 1'b0;
               overlap_in = 1'b0;
               cnt_in     = '0;
               granted_in = '0;
               status_in  = ST_OK;
               if (req_command == CMD_ALLOCATE) begin
                  if (req_region_size == '0 || req_region_size > largest_ff) begin
                     status_in = ST_BAD_REQUEST;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  if (req_region_size == '0 || req_end > MEM_END) begin
                     status_in = ST_BAD_RELEASE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end

         S_SCAN, S_REFRESH: begin
            if (cnt_ff < SLOT_CNT) begin
               cnt_in     = cnt_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               if (state_ff == S_REFRESH) begin
                  if (rd_v_ff && e_len > max_ff) begin
                     max_in = e_len;
                  end
               end else if (cmd_ff == CMD_ALLOCATE) begin
                  if (rd_v_ff && e_len >= size_ff) begin
                     if (!found_ff ||
                         (fit_ff == FIT_FIRST && e_start < pick_start_ff) ||
                         (fit_ff != FIT_FIRST && (e_len < pick_len_ff ||
                          (e_len == pick_len_ff && e_start < pick_start_ff)))) begin
                        found_in      = 1'b1;
                        pick_in       = rd_idx_ff;
                        pick_start_in = e_start;
                        pick_len_in   = e_len;
                     end
                  end
               end else begin
                  if (!rd_v_ff) begin
                     if (!spare_f_ff) begin
                        spare_f_in = 1'b1;
                        spare_in   = rd_idx_ff;
                     end
                  end else begin
                     if ({2'b00, start_ff} < e_end && {2'b00, e_start} < end_ff) begin
                        overlap_in = 1'b1;
                     end
                     if (e_end == {2'b00, start_ff}) begin
                        prev_f_in   = 1'b1;
                        prev_in     = rd_idx_ff;
                        prev_len_in = e_len;
                     end
                     if ({2'b00, e_start} == end_ff) begin
                        next_f_in   = 1'b1;
                        next_in     = rd_idx_ff;
                        next_len_in = e_len;
                     end
                  end
               end
            end
            if (cnt_ff == SLOT_CNT && !rd_pend_ff) begin
               cnt_in = '0;
               if (state_ff == S_REFRESH) begin
                  largest_in = max_ff;
                  state_in   = S_DONE;
               end else if (cmd_ff == CMD_RELEASE && overlap_ff) begin
                  status_in = ST_BAD_RELEASE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end

         S_APPLY: begin
            max_in   = '0;
            cnt_in   = '0;
            state_in = S_REFRESH;
            if (cmd_ff == CMD_ALLOCATE) begin
               if (!found_ff) begin
                  status_in = ST_BAD_REQUEST;
               end else begin
                  granted_in = pick_start_ff + new_len[14:0];
                  mem_we = 1'b1;
                  mem_wa = pick_ff;
                  mem_wd.seg_start  = pick_start_ff;
                  mem_wd.seg_length = new_len;
                  if (pick_ff == '0) begin
                     init0_in = 1'b0;
                  end
                  if (new_len == '0) begin
                     valid_in[pick_ff] = 1'b0;
                  end
               end
            end else if (prev_f_ff) begin
               mem_we = 1'b1;
               mem_wa = prev_ff;
               mem_wd.seg_start  = start_ff - prev_len_ff[14:0];
               mem_wd.seg_length = prev_len_ff + size_ff + (next_f_ff ? next_len_ff : 16'd0);
               if (prev_ff == '0) begin
                  init0_in = 1'b0;
               end
               if (next_f_ff) begin
                  valid_in[next_ff] = 1'b0;
               end
            end else if (next_f_ff) begin
               mem_we = 1'b1;
               mem_wa = next_ff;
               mem_wd.seg_start  = start_ff;
               mem_wd.seg_length = next_len_ff + size_ff;
               if (next_ff == '0) begin
                  init0_in = 1'b0;
               end
            end else if (spare_f_ff) begin
               mem_we = 1'b1;
               mem_wa = spare_ff;
               mem_wd.seg_start  = start_ff;
               mem_wd.seg_length = size_ff;
               valid_in[spare_ff] = 1'b1;
               if (spare_ff == '0) begin
                  init0_in = 1'b0;
               end
            end else begin
               status_in = ST_TABLE_FULL;
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/pafbf_checker.sv
module pafbf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic [14:0] rsp_granted_start,
   input logic [15:0] rsp_largest_free
);
   import pafbf_pkg::*;

   // an accepted item holds busy until its result has gone out
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result without item in flight");

   a_fail_zero_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_granted_start == '0))
      else $error("nonzero grant on failed item");

   a_largest_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_largest_free <= 16'(MEMORY_UNITS)))
      else $error("largest free above memory size");

endmodule

bind partition_allocator_first_best_fit pafbf_checker u_pafbf_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_strobe(rsp_strobe),
   .rsp_status(rsp_status),
   .rsp_granted_start(rsp_granted_start),
   .rsp_largest_free(rsp_largest_free)
);
